@@ design/sdff_pkg.sv @@
// Shared constants and helpers for the signed decimal field formatter.
`timescale 1ns / 1ps

package sdff_pkg;

    // Cap on characters emitted for one request.
    localparam int MAX_OUT_CHARS = 64;
    localparam int IDX_W         = $clog2(MAX_OUT_CHARS);

    // BCD accumulator: twenty digits cover any 64-bit magnitude.
    localparam int NUM_DIGITS = 20;
    localparam int BCD_W      = 4 * NUM_DIGITS;

    typedef logic [BCD_W-1:0] t_bcd;
    typedef logic [4:0]       t_ndig;

    // Length modes.
    localparam logic [2:0] MODE_INT   = 3'd0;
    localparam logic [2:0] MODE_LONG  = 3'd1;
    localparam logic [2:0] MODE_LLONG = 3'd2;
    localparam logic [2:0] MODE_SHORT = 3'd3;
    localparam logic [2:0] MODE_CHAR  = 3'd4;

    // Characters.
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Double-dabble correction of one BCD digit before the shift.
    function automatic logic [3:0] dd_adjust(input logic [3:0] d);
        dd_adjust = (d >= 4'd5) ? 4'(d + 4'd3) : d;
    endfunction

endpackage

@@ design/signed_decimal_field_formatter.sv @@
// Top level: printf %d style formatter, one character out per result.
`timescale 1ns / 1ps

// Usage
//   Input channel (i_in_valid / o_in_stall): one request carries the value,
//   length mode, width, precision and the four flags. A request is taken at
//   a rising edge with i_in_valid high and o_in_stall low; the block works on
//   one request at a time and holds o_in_stall high until its final result
//   has been loaded into the output register.
//   Output channel (o_out_valid / i_out_stall): one character per result,
//   o_last marking the final one. A request that yields no characters gives
//   a single result with o_char_valid low and o_last high.
//   Sequence: the magnitude is converted by a bit-serial double-dabble loop,
//   one bit per cycle over the length mode's size (8, 16, 32 or 64 bits),
//   then leading zero digits are dropped, a setup state sets up the field
//   counts and characters leave one per cycle while the output is not
//   stalled.
//   Stall: while i_out_stall is high a held result stays in the output
//   register and no further character is generated; nothing is lost or repeated.
//   Reset (i_rst_n low, synchronous): drops any request in progress, empties
//   the output register and returns to idle, ready for a new request.
module signed_decimal_field_formatter
    import sdff_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic signed [63:0] i_value,
    input  logic [2:0]        i_length_mode,
    input  logic [5:0]        i_width,
    input  logic signed [6:0] i_precision,
    input  logic              i_left_justify,
    input  logic              i_zero_pad,
    input  logic              i_plus_sign,
    input  logic              i_space_sign,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_out_char,
    output logic              o_char_valid,
    output logic              o_last
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CONV  = 3'd1;
    localparam logic [2:0] S_NORM  = 3'd2;
    localparam logic [2:0] S_SETUP = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [6:0]       r_cnt, n_cnt;
    logic [63:0]      r_mag, n_mag;
    t_bcd             r_bcd, n_bcd;
    t_ndig            r_nd, n_nd;
    logic             r_nodig, n_nodig;
    logic             r_prec_given, n_prec_given;
    logic [5:0]       r_prec, n_prec;
    logic [5:0]       r_width, n_width;
    logic             r_left, n_left;
    logic             r_zpad, n_zpad;
    logic             r_has_sign, n_has_sign;
    logic [7:0]       r_sign_ch, n_sign_ch;
    logic [5:0]       r_padl, n_padl;
    logic [5:0]       r_zc, n_zc;
    logic [5:0]       r_padr, n_padr;
    t_ndig            r_dc, n_dc;
    logic [5:0]       r_rem, n_rem;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_ov, n_ov;
    logic [7:0]       r_oc, n_oc;
    logic             r_ocv, n_ocv;
    logic             r_olast, n_olast;

    logic             w_accept;
    logic [63:0]      w_raw;
    logic [63:0]      w_mask;
    logic             w_neg;
    logic [63:0]      w_mag;
    logic [63:0]      w_mag_al;
    logic [6:0]       w_bits;
    t_bcd             w_bcd_adj;
    t_ndig            w_nd_eff;
    logic [5:0]       w_zeros;
    logic [6:0]       w_total;
    logic [5:0]       w_pad;
    logic             w_load;
    logic             w_fin;

    assign o_in_stall   = (r_state != S_IDLE);
    assign w_accept     = i_in_valid && !o_in_stall;
    assign o_out_valid  = r_ov;
    assign o_out_char   = r_oc;
    assign o_char_valid = r_ocv;
    assign o_last       = r_olast;

    // Narrow by length mode, take the sign from the narrowed value's top bit, then take the magnitude.
    always_comb begin
        unique case (i_length_mode)
            MODE_LONG, MODE_LLONG: begin
                w_mask = {64{1'b1}};
                w_bits = 7'd64;
                w_neg  = i_value[63];
            end
            MODE_SHORT: begin
                w_mask = {48'd0, 16'hFFFF};
                w_bits = 7'd16;
                w_neg  = i_value[15];
            end
            MODE_CHAR: begin
                w_mask = {56'd0, 8'hFF};
                w_bits = 7'd8;
                w_neg  = i_value[7];
            end
            default: begin
                w_mask = {32'd0, 32'hFFFF_FFFF};
                w_bits = 7'd32;
                w_neg  = i_value[31];
            end
        endcase
        w_raw = i_value & w_mask;
        w_mag = w_neg ? ((~w_raw + 64'd1) & w_mask) : w_raw;
        // Left-align so the conversion loop always takes the top bit.
        unique case (w_bits)
            7'd8:    w_mag_al = {w_mag[7:0], 56'd0};
            7'd16:   w_mag_al = {w_mag[15:0], 48'd0};
            7'd32:   w_mag_al = {w_mag[31:0], 32'd0};
            default: w_mag_al = w_mag;
        endcase
    end

    // Double-dabble correction on every digit, independent per digit.
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            w_bcd_adj[4*d +: 4] = dd_adjust(r_bcd[4*d +: 4]);
        end
    end

    // Field arithmetic for the setup cycle.
    always_comb begin
        w_nd_eff = r_nodig ? t_ndig'(0) : r_nd;
        w_zeros  = (r_prec_given && (r_prec > {1'b0, w_nd_eff}))
                   ? 6'(r_prec - {1'b0, w_nd_eff}) : 6'd0;
        w_total  = {6'd0, r_has_sign} + {1'b0, w_zeros} + {2'd0, w_nd_eff};
        w_pad    = ({1'b0, r_width} > w_total)
                   ? 6'({1'b0, r_width} - w_total) : 6'd0;
    end

    assign w_load = (r_state == S_EMIT) && (!r_ov || !i_out_stall);
    assign w_fin  = (r_rem == 6'd1) || (r_idx == IDX_W'(MAX_OUT_CHARS - 1));

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_mag        = r_mag;
        n_bcd        = r_bcd;
        n_nd         = r_nd;
        n_nodig      = r_nodig;
        n_prec_given = r_prec_given;
        n_prec       = r_prec;
        n_width      = r_width;
        n_left       = r_left;
        n_zpad       = r_zpad;
        n_has_sign   = r_has_sign;
        n_sign_ch    = r_sign_ch;
        n_padl       = r_padl;
        n_zc         = r_zc;
        n_padr       = r_padr;
        n_dc         = r_dc;
        n_rem        = r_rem;
        n_idx        = r_idx;
        n_ov         = r_ov;
        n_oc         = r_oc;
        n_ocv        = r_ocv;
        n_olast      = r_olast;

        // Drop the held result once the receiver takes it.
        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state      = S_CONV;
                    n_cnt        = w_bits;
                    n_mag        = w_mag_al;
                    n_bcd        = '0;
                    n_nd         = t_ndig'(NUM_DIGITS);
                    n_prec_given = !i_precision[6];
                    n_prec       = (i_precision[5:0] == 6'd63) ? 6'd62 : i_precision[5:0];
                    n_nodig      = !i_precision[6] && (i_precision[5:0] == 6'd0)
                                   && (w_raw == 64'd0);
                    n_width      = i_width;
                    n_left       = i_left_justify;
                    n_zpad       = !i_left_justify && i_zero_pad && i_precision[6];
                    n_has_sign   = w_neg || i_plus_sign || i_space_sign;
                    n_sign_ch    = w_neg ? CH_MINUS : (i_plus_sign ? CH_PLUS : CH_SPACE);
                end
            end
            S_CONV: begin
                // Shift one magnitude bit into the corrected BCD word.
                n_bcd = {w_bcd_adj[BCD_W-2:0], r_mag[63]};
                n_mag = {r_mag[62:0], 1'b0};
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                // Strip leading zero digits, keeping at least one.
                if ((r_bcd[BCD_W-1 -: 4] == 4'd0) && (r_nd > t_ndig'(1))) begin
                    n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
                    n_nd  = r_nd - t_ndig'(1);
                end else begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_dc  = w_nd_eff;
                n_rem = 6'(w_total + {1'b0, w_pad});
                n_idx = '0;
                if (r_left) begin
                    n_padl = 6'd0;
                    n_zc   = w_zeros;
                    n_padr = w_pad;
                end else if (r_zpad) begin
                    n_padl = 6'd0;
                    n_zc   = w_pad;
                    n_padr = 6'd0;
                end else begin
                    n_padl = w_pad;
                    n_zc   = w_zeros;
                    n_padr = 6'd0;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_load) begin
                    n_ov = 1'b1;
                    if (r_rem == 6'd0) begin
                        // Nothing to print: mark the end with an empty result.
                        n_oc    = CH_NUL;
                        n_ocv   = 1'b0;
                        n_olast = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_ocv   = 1'b1;
                        n_olast = w_fin;
                        n_rem   = r_rem - 6'd1;
                        n_idx   = r_idx + IDX_W'(1);
                        priority if (r_padl != 6'd0) begin
                            n_oc   = CH_SPACE;
                            n_padl = r_padl - 6'd1;
                        end else if (r_has_sign) begin
                            n_oc       = r_sign_ch;
                            n_has_sign = 1'b0;
                        end else if (r_zc != 6'd0) begin
                            n_oc = CH_ZERO;
                            n_zc = r_zc - 6'd1;
                        end else if (r_dc != t_ndig'(0)) begin
                            n_oc  = CH_ZERO | {4'd0, r_bcd[BCD_W-1 -: 4]};
                            n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
                            n_dc  = r_dc - t_ndig'(1);
                        end else begin
                            n_oc   = CH_SPACE;
                            n_padr = r_padr - 6'd1;
                        end
                        if (w_fin) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_cnt        <= n_cnt;
        r_mag        <= n_mag;
        r_bcd        <= n_bcd;
        r_nd         <= n_nd;
        r_nodig      <= n_nodig;
        r_prec_given <= n_prec_given;
        r_prec       <= n_prec;
        r_width      <= n_width;
        r_left       <= n_left;
        r_zpad       <= n_zpad;
        r_has_sign   <= n_has_sign;
        r_sign_ch    <= n_sign_ch;
        r_padl       <= n_padl;
        r_zc         <= n_zc;
        r_padr       <= n_padr;
        r_dc         <= n_dc;
        r_rem        <= n_rem;
        r_idx        <= n_idx;
        r_oc         <= n_oc;
        r_ocv        <= n_ocv;
        r_olast      <= n_olast;
    end

    // A taken request keeps the input side stalled in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after request taken");

    // An empty result always closes its request.
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_char_valid) |-> o_last)
        else $error("empty result without last");

    // A held result that is not the last one means the request is still open.
    a_open_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> o_in_stall)
        else $error("block idle before last result");

    // Only sign, space and decimal digit characters are emitted.
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_char_valid) |->
        ((o_out_char == CH_SPACE) || (o_out_char == CH_PLUS) || (o_out_char == CH_MINUS)
         || ((o_out_char >= CH_ZERO) && (o_out_char <= CH_NINE))))
        else $error("unexpected output character");

endmodule
